@@ rtl/core/sstf_pkg.sv @@
// Shared constants for the shortest-seek-time-first disk request scheduler:
// field widths, action and status codes, and parameter defaults.
// No dependencies; sstf_disk_request_scheduler in rtl/core refers to this package by scoped names.
package sstf_pkg;

   // Field widths of the request and response beats.
   localparam int ACTION_W = 2;
   localparam int REQ_W    = 4;
   localparam int TRACK_W  = 10;
   localparam int STATUS_W = 2;
   localparam int MAXQ_W   = 5;

   // Parameter defaults for the top level.
   localparam int REQUESTERS_DEF = 16;
   localparam int TRACKS_DEF     = 1024;

   // Reset value of the queue depth register.
   localparam logic [MAXQ_W-1:0] MAXQ_RESET = 5'd5;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_JOIN   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RETIRE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_PENDING = 2'd3;

endpackage

@@ rtl/core/sstf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by the scheduler to hold pending track numbers.
module sstf_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sstf_disk_request_scheduler.sv @@
// Each accepted item passes through S_CHECK and S_DONE before its beat enters the output
// register; an item that triggers a serve also passes through S_SCAN, which checks every slot.
// One item at a time; the next is taken once the previous beat is in the output register.
// The scan reads one slot a cycle from the track RAM through one distance comparator.
// Reset (synchronous, active high) clears all slots, head, counts and sets the queue depth to 5.
// Top level of the scheduler; depends on sstf_pkg and sstf_ram.
module sstf_disk_request_scheduler #(
   parameter int REQUESTERS = sstf_pkg::REQUESTERS_DEF,
   parameter int TRACKS     = sstf_pkg::TRACKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sstf_pkg::ACTION_W-1:0]   req_action,
   input  logic [sstf_pkg::REQ_W-1:0]      req_requester,
   input  logic [sstf_pkg::TRACK_W-1:0]    req_track,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sstf_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_served,
   output logic [sstf_pkg::REQ_W-1:0]      rsp_served_requester,
   output logic [sstf_pkg::TRACK_W-1:0]    rsp_served_track,
   // Configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sstf_pkg::MAXQ_W-1:0]     csr_max_queue
);

   localparam int IDX_W    = $clog2(REQUESTERS);
   localparam int CNT_W    = $clog2(REQUESTERS + 1);
   localparam int TH_W     = (CNT_W > sstf_pkg::MAXQ_W) ? CNT_W : sstf_pkg::MAXQ_W;
   localparam int TW       = sstf_pkg::TRACK_W;
   localparam int TrkTop   = (TRACKS > (1 << TW)) ? ((1 << TW) - 1) : (TRACKS - 1);
   localparam logic [16:0]      TRACKS_V = 17'(TRACKS);
   localparam logic [TW-1:0]    TRK_TOP  = TW'(TrkTop);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REQUESTERS - 1);
   localparam logic [CNT_W-1:0] LIVE_TOP = CNT_W'(REQUESTERS);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [REQUESTERS-1:0]         slot_valid_ff, slot_valid_in;
   logic [TW-1:0]                 head_ff, head_in;
   logic [CNT_W-1:0]              pending_ff, pending_in;
   logic [CNT_W-1:0]              live_ff, live_in;
   logic [sstf_pkg::MAXQ_W-1:0]   maxq_ff, maxq_in;
   logic [sstf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          need_ff, need_in;
   logic [IDX_W-1:0]              scan_cnt_ff, scan_cnt_in;
   logic                          issue_ff, issue_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [TW-1:0]                 best_trk_ff, best_trk_in;
   logic [TW-1:0]                 best_d_ff, best_d_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sstf_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_served_ff, rsp_served_in;
   logic [sstf_pkg::REQ_W-1:0]    rsp_req_ff, rsp_req_in;
   logic [TW-1:0]                 rsp_trk_ff, rsp_trk_in;

   logic                          req_fire;
   logic                          req_ok;
   logic [IDX_W-1:0]              req_idx;
   logic [TW-1:0]                 trk_sat;
   logic [sstf_pkg::MAXQ_W-1:0]   mq_eff;
   logic [TH_W-1:0]               live_ext, mq_ext, thr, pend_ext;
   logic                          at_thr;
   logic [TW-1:0]                 seek_d;
   logic                          rsp_load;
   logic                          ram_we;
   logic [TW-1:0]                 ram_rd_data;

   // Handshakes.
   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Request decode: slot index check and track saturation.
   assign req_ok  = 32'(req_requester) < 32'(REQUESTERS);
   assign req_idx = IDX_W'(req_requester);
   assign trk_sat = ({7'd0, req_track} >= TRACKS_V) ? TRK_TOP : req_track;
   assign ram_we  = req_fire && (req_action == sstf_pkg::ACT_SUBMIT) && req_ok
                    && !slot_valid_ff[req_idx] && !at_thr;

   // Serve threshold: min(live count, queue depth), with a depth of zero treated as one.
   assign mq_eff   = (maxq_ff == '0) ? sstf_pkg::MAXQ_W'(1) : maxq_ff;
   assign live_ext = TH_W'(live_ff);
   assign mq_ext   = TH_W'(mq_eff);
   assign thr      = (live_ext < mq_ext) ? live_ext : mq_ext;
   assign pend_ext = TH_W'(pending_ff);
   assign at_thr   = (pend_ext >= thr);

   // The shared unit: distance from the head to the slot track just read.
   assign seek_d = (ram_rd_data > head_ff) ? (ram_rd_data - head_ff) : (head_ff - ram_rd_data);

   // Track store, one entry per requester.
   sstf_ram #(
      .WIDTH (TW),
      .DEPTH (REQUESTERS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_idx),
      .wr_data (trk_sat),
      .rd_addr (scan_cnt_ff),
      .rd_data (ram_rd_data)
   );

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      head_in       = head_ff;
      pending_in    = pending_ff;
      live_in       = live_ff;
      maxq_in       = maxq_ff;
      status_in     = status_ff;
      need_in       = need_ff;
      scan_cnt_in   = scan_cnt_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_trk_in   = best_trk_ff;
      best_d_in     = best_d_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_served_in = rsp_served_ff;
      rsp_req_in    = rsp_req_ff;
      rsp_trk_in    = rsp_trk_ff;

      if (csr_valid && csr_ready) begin
         maxq_in = csr_max_queue;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Apply the action of the accepted beat.
            if (req_fire) begin
               status_in = sstf_pkg::ST_OK;
               state_in  = S_CHECK;
               unique case (req_action)
                  sstf_pkg::ACT_JOIN: begin
                     if (live_ff >= LIVE_TOP) begin
                        status_in = sstf_pkg::ST_LIMIT;
                     end else begin
                        live_in = live_ff + CNT_W'(1);
                     end
                  end
                  sstf_pkg::ACT_SUBMIT: begin
                     if (!req_ok || slot_valid_ff[req_idx] || at_thr) begin
                        status_in = sstf_pkg::ST_BUSY;
                     end else begin
                        slot_valid_in[req_idx] = 1'b1;
                        pending_in = pending_ff + CNT_W'(1);
                     end
                  end
                  sstf_pkg::ACT_RETIRE: begin
                     if (live_ff == '0) begin
                        status_in = sstf_pkg::ST_LIMIT;
                     end else if (req_ok && slot_valid_ff[req_idx]) begin
                        status_in = sstf_pkg::ST_PENDING;
                     end else begin
                        live_in = live_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = sstf_pkg::ST_BUSY;
                  end
               endcase
            end
         end
         S_CHECK: begin
            // Decide whether this step serves a request.
            need_in     = (pending_ff != '0) && at_thr;
            found_in    = 1'b0;
            scan_cnt_in = '0;
            issue_in    = (pending_ff != '0) && at_thr;
            state_in    = ((pending_ff != '0) && at_thr) ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            // Issue one slot read per cycle.
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_cnt_ff;
               if (scan_cnt_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_cnt_in = scan_cnt_ff + IDX_W'(1);
               end
            end
            // Compare the slot read last cycle against the best so far.
            if (chk_vld_ff) begin
               if (slot_valid_ff[chk_idx_ff] && (!found_ff || (seek_d < best_d_ff))) begin
                  found_in    = 1'b1;
                  best_idx_in = chk_idx_ff;
                  best_trk_in = ram_rd_data;
                  best_d_in   = seek_d;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // Commit the serve and post the response beat.
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_served_in = found_ff;
               rsp_req_in    = found_ff ? sstf_pkg::REQ_W'(best_idx_ff) : '0;
               rsp_trk_in    = found_ff ? best_trk_ff : '0;
               if (found_ff) begin
                  slot_valid_in[best_idx_ff] = 1'b0;
                  head_in    = best_trk_ff;
                  pending_in = pending_ff - CNT_W'(1);
               end
               found_in = 1'b0;
               need_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_valid_ff <= '0;
         head_ff       <= '0;
         pending_ff    <= '0;
         live_ff       <= '0;
         maxq_ff       <= sstf_pkg::MAXQ_RESET;
         need_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         chk_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         head_ff       <= head_in;
         pending_ff    <= pending_in;
         live_ff       <= live_in;
         maxq_ff       <= maxq_in;
         need_ff       <= need_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      scan_cnt_ff   <= scan_cnt_in;
      chk_idx_ff    <= chk_idx_in;
      best_idx_ff   <= best_idx_in;
      best_trk_ff   <= best_trk_in;
      best_d_ff     <= best_d_in;
      rsp_status_ff <= rsp_status_in;
      rsp_served_ff <= rsp_served_in;
      rsp_req_ff    <= rsp_req_in;
      rsp_trk_ff    <= rsp_trk_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_served           = rsp_served_ff;
   assign rsp_served_requester = rsp_req_ff;
   assign rsp_served_track     = rsp_trk_ff;

   // The pending count always matches the number of occupied slots.
   a_pending_matches_slots: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) == $countones(slot_valid_ff))
      else $error("pending count differs from occupied slots");

   // A scan that was needed always finds an occupied slot.
   a_scan_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && need_ff) |-> found_ff)
      else $error("serve scan found no occupied slot");

   // The slot chosen for service is still occupied when it is committed.
   a_best_occupied: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && found_ff) |-> slot_valid_ff[best_idx_ff])
      else $error("served slot is not occupied");

   // A serve moves the head to the served track on the next cycle.
   a_head_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && found_ff) |=> (head_ff == $past(best_trk_ff)))
      else $error("head did not move to the served track");

   // The live count never exceeds the number of requesters.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_TOP)
      else $error("live count above requester count");

endmodule

@@ sim/sstf_dispatch_checker.sv @@
// Checker for the SSTF disk request scheduler: watches the request, response and
// queue-depth channels, predicts each response beat and compares it on arrival.
// Depends on sstf_pkg for field widths, action and status codes.
module sstf_dispatch_checker #(
   parameter int REQUESTERS = sstf_pkg::REQUESTERS_DEF,
   parameter int TRACKS     = sstf_pkg::TRACKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sstf_pkg::ACTION_W-1:0]   req_action,
   input  logic [sstf_pkg::REQ_W-1:0]      req_requester,
   input  logic [sstf_pkg::TRACK_W-1:0]    req_track,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sstf_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            rsp_served,
   input  logic [sstf_pkg::REQ_W-1:0]      rsp_served_requester,
   input  logic [sstf_pkg::TRACK_W-1:0]    rsp_served_track,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sstf_pkg::MAXQ_W-1:0]     csr_max_queue,
   output int                              fail_count,
   output int                              outstanding,
   output int                              dispatch_count,
   output int                              refusal_count
);
   import sstf_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                served;
      logic [REQ_W-1:0]    who;
      logic [TRACK_W-1:0]  trk;
   } dispatch_type;

   // Shadow copy of the scheduler state.
   bit                 occupied [REQUESTERS];
   logic [TRACK_W-1:0] slot_trk [REQUESTERS];
   logic [TRACK_W-1:0] head_trk;
   int                 pend_cnt;
   int                 live_cnt;
   logic [MAXQ_W-1:0]  depth_cfg;
   dispatch_type       expected_q [$];

   // Number of pending requests at which one must be dispatched.
   function automatic int serve_limit();
      int depth;
      depth = (depth_cfg == '0) ? 1 : int'(depth_cfg);
      return (live_cnt < depth) ? live_cnt : depth;
   endfunction

   // Applies one request to the shadow state and returns the beat it should produce.
   function automatic dispatch_type predict_dispatch(input logic [ACTION_W-1:0] act,
                                                     input logic [REQ_W-1:0]    who,
                                                     input logic [TRACK_W-1:0]  trk_in);
      dispatch_type res;
      int           trk;
      int           seek_len;
      int           best;
      int           best_dist;
      int           i;
      bit           in_range;
      bit           found;
      res        = '0;
      res.status = ST_OK;
      trk        = (int'(trk_in) >= TRACKS) ? TRACKS - 1 : int'(trk_in);
      in_range   = int'(who) < REQUESTERS;
      case (act)
         ACT_JOIN: begin
            if (live_cnt >= REQUESTERS) res.status = ST_LIMIT;
            else live_cnt++;
         end
         ACT_SUBMIT: begin
            if (!in_range || occupied[who] || pend_cnt >= serve_limit()) begin
               res.status = ST_BUSY;
            end else begin
               occupied[who] = 1'b1;
               slot_trk[who] = TRACK_W'(trk);
               pend_cnt++;
            end
         end
         ACT_RETIRE: begin
            if (live_cnt == 0) res.status = ST_LIMIT;
            else if (in_range && occupied[who]) res.status = ST_PENDING;
            else live_cnt--;
         end
         default: res.status = ST_BUSY;
      endcase

      // Dispatch the nearest pending track once the queue is deep enough; the
      // strict compare keeps the lowest requester on equal distances.
      if (pend_cnt != 0 && pend_cnt >= serve_limit()) begin
         found     = 1'b0;
         best      = 0;
         best_dist = 0;
         for (i = 0; i < REQUESTERS; i++) begin
            if (occupied[i]) begin
               seek_len = (slot_trk[i] > head_trk) ? int'(slot_trk[i]) - int'(head_trk)
                                                   : int'(head_trk) - int'(slot_trk[i]);
               if (!found || seek_len < best_dist) begin
                  found     = 1'b1;
                  best      = i;
                  best_dist = seek_len;
               end
            end
         end
         if (found) begin
            res.served     = 1'b1;
            res.who        = REQ_W'(best);
            res.trk        = slot_trk[best];
            head_trk       = slot_trk[best];
            occupied[best] = 1'b0;
            pend_cnt--;
         end
      end
      return res;
   endfunction

   // Track every accepted beat on the three channels.
   always @(posedge clock) begin
      dispatch_type want;
      dispatch_type got;
      if (reset) begin
         for (int i = 0; i < REQUESTERS; i++) begin
            occupied[i] = 1'b0;
            slot_trk[i] = '0;
         end
         head_trk       = '0;
         pend_cnt       = 0;
         live_cnt       = 0;
         depth_cfg      = MAXQ_RESET;
         fail_count     = 0;
         dispatch_count = 0;
         refusal_count  = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) depth_cfg = csr_max_queue;

         if (req_valid && !req_stall) begin
            want = predict_dispatch(req_action, req_requester, req_track);
            expected_q.push_back(want);
            if (want.served) dispatch_count++;
            if (want.status != ST_OK) refusal_count++;
         end

         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_served, rsp_served_requester, rsp_served_track};
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with nothing expected: status=%0d served=%0d",
                        $time, got.status, got.served);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: mismatch expected status=%0d served=%0d requester=%0d track=%0d",
                           $time, want.status, want.served, want.who, want.trk);
                  $display("%0t:          actual   status=%0d served=%0d requester=%0d track=%0d",
                           $time, got.status, got.served, got.who, got.trk);
               end
            end
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Top of the SSTF disk request scheduler testbench: clock, reset, request and
// queue-depth stimulus, response back-pressure, watchdog and the verdict.
// Depends on sstf_pkg, sstf_disk_request_scheduler and sstf_dispatch_checker.
module tb_top;
   import sstf_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 125;
   localparam int SETTLE_CYCLES = REQUESTERS_DEF + 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AFTER    = 400;
   localparam int QUIET_LIMIT   = 4000;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action    = '0;
   logic [REQ_W-1:0]    req_requester = '0;
   logic [TRACK_W-1:0]  req_track     = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_served;
   logic [REQ_W-1:0]    rsp_served_requester;
   logic [TRACK_W-1:0]  rsp_served_track;
   logic                csr_valid     = 1'b0;
   logic                csr_ready;
   logic [MAXQ_W-1:0]   csr_max_queue = '0;

   int fail_count;
   int pending_beats;
   int dispatch_count;
   int refusal_count;
   int items_sent    = 0;
   int depth_writes  = 0;
   bit steady_flow   = 1'b0;

   sstf_disk_request_scheduler u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_requester        (req_requester),
      .req_track            (req_track),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_served           (rsp_served),
      .rsp_served_requester (rsp_served_requester),
      .rsp_served_track     (rsp_served_track),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_queue        (csr_max_queue)
   );

   sstf_dispatch_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_requester        (req_requester),
      .req_track            (req_track),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_served           (rsp_served),
      .rsp_served_requester (rsp_served_requester),
      .rsp_served_track     (rsp_served_track),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_queue        (csr_max_queue),
      .fail_count           (fail_count),
      .outstanding          (pending_beats),
      .dispatch_count       (dispatch_count),
      .refusal_count        (refusal_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request beat, with an occasional idle gap first unless steady_flow is set,
   // and returns at the edge that accepts it.
   task automatic send_beat(input logic [ACTION_W-1:0] act,
                            input logic [REQ_W-1:0]    who,
                            input logic [TRACK_W-1:0]  trk);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 8) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_requester <= who;
      req_track     <= trk;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Lets every expected beat arrive, then gives the block time to settle.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the queue depth register; only called while the block is idle.
   task automatic write_depth(input logic [MAXQ_W-1:0] depth);
      csr_valid     <= 1'b1;
      csr_max_queue <= depth;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      depth_writes++;
   endtask

   // Action mix: mode 0 builds up requesters, mode 1 is submit heavy and
   // mode 2 winds requesters down; a few beats carry the unused action.
   function automatic logic [ACTION_W-1:0] pick_action(input int mode);
      int roll;
      int join_w;
      int submit_w;
      roll = $urandom_range(0, 99);
      case (mode)
         0:       begin join_w = 45; submit_w = 40; end
         1:       begin join_w = 15; submit_w = 65; end
         default: begin join_w = 10; submit_w = 40; end
      endcase
      if (roll < 4) return ACT_UNUSED;
      if (roll < 4 + join_w) return ACT_JOIN;
      if (roll < 4 + join_w + submit_w) return ACT_SUBMIT;
      return ACT_RETIRE;
   endfunction

   // Favor a few requesters so that slots collide.
   function automatic logic [REQ_W-1:0] pick_requester();
      if ($urandom_range(0, 99) < 30) return REQ_W'($urandom_range(0, 3));
      return REQ_W'($urandom_range(0, 15));
   endfunction

   // Coarse track grid and the two ends make equal distances common.
   function automatic logic [TRACK_W-1:0] pick_track();
      int roll;
      int grid;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return '1;
      if (roll < 45) begin
         grid = $urandom_range(0, 8) * 128;
         return TRACK_W'((grid > 1023) ? 1023 : grid);
      end
      return TRACK_W'($urandom_range(0, 1023));
   endfunction

   // Response side: random stall, one long hold-off so the block backs up.
   initial begin : rsp_side
      int  beats_seen;
      bit  held;
      beats_seen = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) beats_seen++;
         if (!held && beats_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady_flow && ($urandom_range(0, 99) < 8);
         end
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int depth_plan [7];
      int phase;
      int n;
      depth_plan = '{16, 1, 0, 31, 2, 8, 5};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset queue depth of five.
      send_beat(ACT_RETIRE, 4'd3, 10'd0);      // retire with nobody live
      send_beat(ACT_SUBMIT, 4'd0, 10'd5);      // submit with nobody live
      send_beat(ACT_UNUSED, 4'd15, 10'd1023);  // unused action
      send_beat(ACT_JOIN, 4'd0, 10'd0);
      send_beat(ACT_JOIN, 4'd1, 10'd0);
      send_beat(ACT_JOIN, 4'd2, 10'd0);
      send_beat(ACT_SUBMIT, 4'd15, 10'd1023);
      send_beat(ACT_SUBMIT, 4'd4, 10'd640);
      send_beat(ACT_SUBMIT, 4'd9, 10'd384);    // third pending request dispatches
      send_beat(ACT_SUBMIT, 4'd4, 10'd0);      // slot already busy
      send_beat(ACT_RETIRE, 4'd4, 10'd0);      // retire while pending
      send_beat(ACT_SUBMIT, 4'd0, 10'd128);    // equal distances, lowest requester wins
      send_beat(ACT_RETIRE, 4'd7, 10'd0);      // retire lowers the threshold
      send_beat(ACT_SUBMIT, 4'd8, 10'd640);
      send_beat(ACT_JOIN, 4'd5, 10'd0);
      send_beat(ACT_JOIN, 4'd6, 10'd0);
      send_beat(ACT_SUBMIT, 4'd0, 10'd0);
      send_beat(ACT_SUBMIT, 4'd15, 10'd1023);
      send_beat(ACT_SUBMIT, 4'd1, 10'd512);
      wait_quiet();

      // Random phases, each at its own queue depth; phase three runs without gaps.
      for (phase = 0; phase < PHASES; phase++) begin
         steady_flow = (phase == 3);
         write_depth(MAXQ_W'((phase < 7) ? depth_plan[phase] : $urandom_range(0, 31)));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_beat(pick_action(phase % 3), pick_requester(), pick_track());
         end
         wait_quiet();
      end
      steady_flow = 1'b0;

      $display("Run covered %0d request beats over %0d queue depth settings (0 and 31 included).",
               items_sent, depth_writes + 1);
      $display("The scheduler dispatched %0d requests and refused %0d beats.",
               dispatch_count, refusal_count);
      if (fail_count == 0 && pending_beats == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
